FILE: rtl/core/gle_pkg.sv
// ----------------------------------------------------------------------------
// gle_pkg
// Shared types and constants of the GIF LZW encoder.
// ----------------------------------------------------------------------------
package gle_pkg;

    localparam int SYMBOL_BITS    = 8;
    localparam int CODE_BITS      = 12;
    localparam int WIDTH_BITS     = 4;
    localparam int IDX_BITS       = CODE_BITS + SYMBOL_BITS;
    localparam int DICT_DEPTH     = 1 << IDX_BITS;
    localparam int CODE_DEPTH     = 1 << CODE_BITS;
    localparam int SUBBLOCK_BYTES = 255;

    localparam logic [CODE_BITS-1:0]  DICT_LIMIT = CODE_BITS'(4095);
    localparam logic [CODE_BITS-1:0]  CLEAR_CODE = CODE_BITS'(1 << SYMBOL_BITS);
    localparam logic [CODE_BITS-1:0]  END_CODE   = CODE_BITS'((1 << SYMBOL_BITS) + 1);
    localparam logic [CODE_BITS-1:0]  FIRST_CODE = CODE_BITS'((1 << SYMBOL_BITS) + 2);
    localparam logic [WIDTH_BITS-1:0] BASE_WIDTH = WIDTH_BITS'(SYMBOL_BITS + 1);

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] sym;
        logic                   last;
    } t_pixel_item;

    typedef struct packed {
        logic [CODE_BITS-1:0]  code;
        logic [WIDTH_BITS-1:0] width;
        logic                  final_word;
    } t_code_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_LOOK,
        ST_RD1,
        ST_DEC,
        ST_FULL,
        ST_F1,
        ST_F2,
        ST_F3
    } t_eng_state;

endpackage

FILE: rtl/core/gle_front.sv
// ----------------------------------------------------------------------------
// gle_front
// Input queue: takes pixel words and holds them for the dictionary engine.
// ----------------------------------------------------------------------------
module gle_front
    import gle_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SYMBOL_BITS-1:0] i_pixel_index,
    input  logic                   i_last_pixel,
    output logic                   o_item_valid,
    output t_pixel_item            o_item,
    input  logic                   i_item_pop
);

    t_pixel_item r_q [4];
    logic [1:0]  r_wr;
    logic [1:0]  r_rd;
    logic [2:0]  r_cnt;
    logic        w_push;
    logic        w_pop;

    assign o_ready      = (r_cnt != 3'd4);
    assign o_item_valid = (r_cnt != 3'd0);
    assign o_item       = r_q[r_rd];
    assign w_push       = i_valid && o_ready;
    assign w_pop        = i_item_pop && o_item_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= '{sym: i_pixel_index, last: i_last_pixel};
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 3'd1;
                2'b01:   r_cnt <= r_cnt - 3'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/core/gle_engine.sv
// ----------------------------------------------------------------------------
// gle_engine
// LZW dictionary engine: looks up prefix and symbol, assigns codes, and
// issues code words with their widths to the bit packer.
// ----------------------------------------------------------------------------
module gle_engine
    import gle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    input  t_pixel_item i_item,
    output logic        o_item_pop,
    output logic        o_word_valid,
    output t_code_word  o_word,
    input  logic        i_word_ready
);

    // The dictionary keeps the code assigned to each prefix and symbol pair.
    // The reverse table keeps the pair that owns each code. An entry counts
    // only if its code was assigned since the last restart and the reverse
    // table still names the same pair, so neither store needs clearing.
    logic [CODE_BITS-1:0] dict_mem [DICT_DEPTH];
    logic [IDX_BITS-1:0]  rev_mem  [CODE_DEPTH];

    t_eng_state            r_state, n_state;
    logic [SYMBOL_BITS-1:0] r_sym, n_sym;
    logic                  r_last, n_last;
    logic [CODE_BITS-1:0]  r_prefix, n_prefix;
    logic                  r_pvalid, n_pvalid;
    logic [WIDTH_BITS-1:0] r_width, n_width;
    logic [CODE_BITS-1:0]  r_highest, n_highest;
    logic                  r_started, n_started;
    logic [IDX_BITS-1:0]   r_idx, n_idx;
    logic [CODE_BITS-1:0]  r_dict_q;
    logic [IDX_BITS-1:0]   r_rev_q;

    logic [IDX_BITS-1:0]   w_look_idx;
    logic [CODE_BITS-1:0]  w_new_code;
    logic                  w_hit;
    logic                  w_we;

    assign w_look_idx = {r_prefix, r_sym};
    assign w_new_code = r_highest + CODE_BITS'(1);
    assign w_hit      = (r_dict_q >= FIRST_CODE) && (r_dict_q <= r_highest)
                        && (r_rev_q == r_idx);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            dict_mem[r_idx]     <= w_new_code;
            rev_mem[w_new_code] <= r_idx;
        end
        if (r_state == ST_LOOK) begin
            r_dict_q <= dict_mem[w_look_idx];
        end
        if (r_state == ST_RD1) begin
            r_rev_q <= rev_mem[r_dict_q];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym  <= n_sym;
        r_last <= n_last;
        r_idx  <= n_idx;
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_prefix  <= '0;
            r_pvalid  <= 1'b0;
            r_width   <= BASE_WIDTH;
            r_highest <= END_CODE;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_prefix  <= n_prefix;
            r_pvalid  <= n_pvalid;
            r_width   <= n_width;
            r_highest <= n_highest;
            r_started <= n_started;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_sym        = r_sym;
        n_last       = r_last;
        n_prefix     = r_prefix;
        n_pvalid     = r_pvalid;
        n_width      = r_width;
        n_highest    = r_highest;
        n_started    = r_started;
        n_idx        = r_idx;
        o_item_pop   = 1'b0;
        o_word_valid = 1'b0;
        o_word       = '{code: CLEAR_CODE, width: r_width, final_word: 1'b0};
        w_we         = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    n_sym      = i_item.sym;
                    n_last     = i_item.last;
                    n_state    = r_started ? ST_LOOK : ST_START;
                end
            end
            ST_START: begin
                o_word_valid = 1'b1;
                if (i_word_ready) begin
                    n_started = 1'b1;
                    n_state   = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (!r_pvalid) begin
                    n_prefix = {{(CODE_BITS-SYMBOL_BITS){1'b0}}, r_sym};
                    n_pvalid = 1'b1;
                    n_state  = r_last ? ST_F1 : ST_IDLE;
                end else begin
                    n_idx   = w_look_idx;
                    n_state = ST_RD1;
                end
            end
            ST_RD1: begin
                n_state = ST_DEC;
            end
            ST_DEC: begin
                if (w_hit) begin
                    n_prefix = r_dict_q;
                    n_state  = r_last ? ST_F1 : ST_IDLE;
                end else begin
                    o_word_valid = 1'b1;
                    o_word.code  = r_prefix;
                    if (i_word_ready) begin
                        w_we      = 1'b1;
                        n_highest = w_new_code;
                        if ({1'b0, w_new_code} >= ((CODE_BITS+1)'(1) << r_width)) begin
                            n_width = r_width + WIDTH_BITS'(1);
                        end
                        n_prefix = {{(CODE_BITS-SYMBOL_BITS){1'b0}}, r_sym};
                        if (w_new_code >= DICT_LIMIT) begin
                            n_state = ST_FULL;
                        end else begin
                            n_state = r_last ? ST_F1 : ST_IDLE;
                        end
                    end
                end
            end
            ST_FULL: begin
                o_word_valid = 1'b1;
                if (i_word_ready) begin
                    n_width   = BASE_WIDTH;
                    n_highest = END_CODE;
                    n_state   = r_last ? ST_F1 : ST_IDLE;
                end
            end
            ST_F1: begin
                o_word_valid = 1'b1;
                o_word.code  = r_prefix;
                if (i_word_ready) begin
                    n_state = ST_F2;
                end
            end
            ST_F2: begin
                o_word_valid = 1'b1;
                if (i_word_ready) begin
                    n_state = ST_F3;
                end
            end
            ST_F3: begin
                o_word_valid = 1'b1;
                o_word       = '{code: END_CODE, width: BASE_WIDTH, final_word: 1'b1};
                if (i_word_ready) begin
                    n_prefix  = '0;
                    n_pvalid  = 1'b0;
                    n_width   = BASE_WIDTH;
                    n_highest = END_CODE;
                    n_started = 1'b0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/gle_packer.sv
// ----------------------------------------------------------------------------
// gle_packer
// Bit packer: queues code words, packs them LSB first into bytes and marks
// sub-block and image ends.
// ----------------------------------------------------------------------------
module gle_packer
    import gle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_word_valid,
    input  t_code_word i_word,
    output logic       o_word_ready,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data_byte,
    output logic       o_block_last,
    output logic [7:0] o_block_length,
    output logic       o_image_last
);

    t_code_word  r_q [4];
    logic [1:0]  r_wr;
    logic [1:0]  r_rd;
    logic [2:0]  r_cnt;
    logic [18:0] r_acc;
    logic [4:0]  r_bits;
    logic        r_flush;
    logic [7:0]  r_bcount;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_blast;
    logic [7:0]  r_out_blen;
    logic        r_out_ilast;

    logic        w_push;
    logic        w_load;
    logic        w_emit;
    logic        w_ilast;
    logic [7:0]  w_nb;
    t_code_word  w_head;

    assign o_word_ready = (r_cnt != 3'd4);
    assign w_push       = i_word_valid && o_word_ready;
    assign w_head       = r_q[r_rd];
    assign w_load       = (r_cnt != 3'd0) && !r_flush && (r_bits < 5'd8);
    assign w_emit       = ((r_bits >= 5'd8) || (r_flush && (r_bits != 5'd0)))
                          && (!r_out_valid || i_ready);
    assign w_ilast      = r_flush && (r_bits <= 5'd8);
    assign w_nb         = r_bcount + 8'd1;

    assign o_valid        = r_out_valid;
    assign o_data_byte    = r_out_byte;
    assign o_block_last   = r_out_blast;
    assign o_block_length = r_out_blen;
    assign o_image_last   = r_out_ilast;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= i_word;
        end
        if (w_emit) begin
            r_out_byte  <= r_acc[7:0];
            r_out_ilast <= w_ilast;
            if ((32'(w_nb) >= SUBBLOCK_BYTES) || w_ilast) begin
                r_out_blast <= 1'b1;
                r_out_blen  <= w_nb;
            end else begin
                r_out_blast <= 1'b0;
                r_out_blen  <= 8'd0;
            end
        end
        if (!i_rst_n) begin
            r_wr        <= '0;
            r_rd        <= '0;
            r_cnt       <= '0;
            r_acc       <= '0;
            r_bits      <= '0;
            r_flush     <= 1'b0;
            r_bcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (w_load) begin
                r_rd    <= r_rd + 2'd1;
                r_acc   <= r_acc | (19'(w_head.code) << r_bits);
                r_bits  <= r_bits + 5'(w_head.width);
                r_flush <= w_head.final_word;
            end else if (w_emit) begin
                r_acc  <= r_acc >> 8;
                r_bits <= (r_bits >= 5'd8) ? (r_bits - 5'd8) : 5'd0;
                if (w_ilast) begin
                    r_flush <= 1'b0;
                end
                if ((32'(w_nb) >= SUBBLOCK_BYTES) || w_ilast) begin
                    r_bcount <= 8'd0;
                end else begin
                    r_bcount <= w_nb;
                end
            end
            case ({w_push, w_load})
                2'b10:   r_cnt <= r_cnt + 3'd1;
                2'b01:   r_cnt <= r_cnt - 3'd1;
                default: r_cnt <= r_cnt;
            endcase
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/core/gif_lzw_encoder_unit.sv
// ----------------------------------------------------------------------------
// gif_lzw_encoder_unit
// GIF LZW encoder: palette indices in, packed code stream bytes out.
// ----------------------------------------------------------------------------
// Input words carry one palette index and a last-pixel flag; output words
// carry one data byte with sub-block marks (end flag and length) and an
// image end flag. Both channels use valid/ready.
// A four-word input queue decouples the sender from the dictionary engine.
// In the steady state the engine takes each pixel through its states in order:
// it takes the word, reads the dictionary, reads the reverse table, and then
// decides and writes; the two dependent memory reads set the engine's pace.
// A new dictionary code needs no state of its own when the code queue has
// room; each extra code word (clear, image end) takes a state of its own.
// The packer emits at most one byte per cycle through an output register;
// each code word passes the code queue and the accumulator on the way there.
// When the receiver stalls, the output register holds, the code queue and
// then the input queue fill, and only then does o_ready fall.
// Reset empties the queues and sets the dictionary to its start state; the
// memories need no clearing pass, stale entries are rejected on lookup.
// ----------------------------------------------------------------------------
module gif_lzw_encoder_unit
    import gle_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SYMBOL_BITS-1:0] i_pixel_index,
    input  logic                   i_last_pixel,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [7:0]             o_data_byte,
    output logic                   o_block_last,
    output logic [7:0]             o_block_length,
    output logic                   o_image_last
);

    logic        w_item_valid;
    t_pixel_item w_item;
    logic        w_item_pop;
    logic        w_word_valid;
    t_code_word  w_word;
    logic        w_word_ready;

    gle_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel_index (i_pixel_index),
        .i_last_pixel  (i_last_pixel),
        .o_item_valid  (w_item_valid),
        .o_item        (w_item),
        .i_item_pop    (w_item_pop)
    );

    gle_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_pop   (w_item_pop),
        .o_word_valid (w_word_valid),
        .o_word       (w_word),
        .i_word_ready (w_word_ready)
    );

    gle_packer u_packer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_word_valid   (w_word_valid),
        .i_word         (w_word),
        .o_word_ready   (w_word_ready),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_data_byte    (o_data_byte),
        .o_block_last   (o_block_last),
        .o_block_length (o_block_length),
        .o_image_last   (o_image_last)
    );

endmodule

FILE: tb/gif_lzw_encoder_unit_tb.sv
// ----------------------------------------------------------------------------
// gif_lzw_encoder_unit_tb
// Self-checking testbench of the GIF LZW encoder.
// ----------------------------------------------------------------------------
// Pixel words are sent through the valid/ready input with random gaps, but
// none in one pass of random images. A behavioral encoder predicts the
// output bytes of each pixel, and a checker compares every output word with
// the oldest predicted one. Tests cover single-pixel images, extreme indices,
// repeating runs that build chains, random images, pixels that assign a new
// code almost every time and a long receiver stall.
// ----------------------------------------------------------------------------
module gif_lzw_encoder_unit_tb;
    import gle_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_last;
        logic [7:0] block_length;
        logic       image_last;
    } t_out_byte;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [SYMBOL_BITS-1:0] i_pixel_index;
    logic                   i_last_pixel;
    logic                   o_valid;
    logic                   i_ready;
    logic [7:0]             o_data_byte;
    logic                   o_block_last;
    logic [7:0]             o_block_length;
    logic                   o_image_last;

    gif_lzw_encoder_unit dut (.*);

    // Predictor state.
    logic [11:0] dict_code [int];
    logic [11:0] pred_prefix;
    logic        pred_prefix_valid;
    int          pred_width;
    int          pred_highest;
    logic [7:0]  pred_buf;
    int          pred_bits;
    int          pred_blk_count;
    logic        pred_started;

    t_out_byte   byte_queue[$];
    t_out_byte   step_bytes[$];
    int          errors;
    bit          idle_enable;
    int          stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("Verification failed");
        $finish;
    end

    function automatic void dict_restart();
        dict_code.delete();
        pred_width   = SYMBOL_BITS + 1;
        pred_highest = (1 << SYMBOL_BITS) + 1;
    endfunction

    function automatic void pred_reset();
        dict_restart();
        pred_prefix       = '0;
        pred_prefix_valid = 1'b0;
        pred_buf          = '0;
        pred_bits         = 0;
        pred_blk_count    = 0;
        pred_started      = 1'b0;
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        t_out_byte w;
        w = '{b, 1'b0, 8'd0, 1'b0};
        pred_blk_count++;
        if (pred_blk_count >= SUBBLOCK_BYTES) begin
            w.block_last   = 1'b1;
            w.block_length = 8'(pred_blk_count);
            pred_blk_count = 0;
        end
        step_bytes.push_back(w);
    endfunction

    function automatic void put_code(int code, int len);
        for (int i = 0; i < len; i++) begin
            pred_buf[pred_bits] = 1'((code >> i) & 1);
            pred_bits++;
            if (pred_bits == 8) begin
                emit_byte(pred_buf);
                pred_buf  = '0;
                pred_bits = 0;
            end
        end
    endfunction

    function automatic void encode_pixel(logic [7:0] sym, logic last);
        int idx;
        step_bytes.delete();
        if (!pred_started) begin
            put_code(CLEAR_CODE, pred_width);
            pred_started = 1'b1;
        end
        if (!pred_prefix_valid) begin
            pred_prefix       = 12'(sym);
            pred_prefix_valid = 1'b1;
        end else begin
            idx = (int'(pred_prefix) << 8) | sym;
            if (dict_code.exists(idx)) begin
                pred_prefix = dict_code[idx];
            end else begin
                put_code(pred_prefix, pred_width);
                pred_highest++;
                dict_code[idx] = 12'(pred_highest);
                if (pred_highest >= (1 << pred_width)) pred_width++;
                if (pred_highest >= DICT_LIMIT) begin
                    put_code(CLEAR_CODE, pred_width);
                    dict_restart();
                end
                pred_prefix = 12'(sym);
            end
        end
        if (last) begin
            put_code(pred_prefix, pred_width);
            put_code(CLEAR_CODE, pred_width);
            put_code(END_CODE, SYMBOL_BITS + 1);
            while (pred_bits != 0) put_code(0, 1);
            if (step_bytes.size() > 0) begin
                step_bytes[$].image_last = 1'b1;
                if (pred_blk_count > 0) begin
                    step_bytes[$].block_last   = 1'b1;
                    step_bytes[$].block_length = 8'(pred_blk_count);
                end
            end
            pred_reset();
        end
        foreach (step_bytes[i]) byte_queue.push_back(step_bytes[i]);
    endfunction

    // Valid stays high from one word to the next unless an idle cycle is
    // drawn; drain() drops it after the last word.
    task automatic send_pixel(logic [7:0] sym, logic last);
        while (idle_enable && $urandom_range(99) < 26) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel_index <= sym;
        i_last_pixel  <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        encode_pixel(sym, last);
        @(negedge i_clk);
    endtask

    // Receiver readiness, with an optional long hold-off.
    always @(negedge i_clk) begin
        if (stall_cycles > 0) begin
            i_ready <= 1'b0;
            stall_cycles <= stall_cycles - 1;
        end else begin
            i_ready <= !(idle_enable && $urandom_range(99) < 26);
        end
    end

    always @(posedge i_clk) begin
        t_out_byte got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_data_byte, o_block_last, o_block_length, o_image_last};
            if (byte_queue.size() == 0) begin
                $display("%0t: unexpected word, actual %h", $time, got);
                errors++;
            end else begin
                want = byte_queue.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch, expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    task automatic test_single_pixels();
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'hA5, 1'b1);
    endtask

    task automatic test_extremes();
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h55, 1'b0);
        send_pixel(8'h55, 1'b1);
    endtask

    // Runs of one index build chains of growing length.
    task automatic test_runs();
        for (int i = 0; i < 12; i++) send_pixel(8'h07, i == 11);
    endtask

    task automatic test_random_images();
        int n;
        for (int img = 0; img < 4; img++) begin
            n = $urandom_range(12, 2);
            for (int i = 0; i < n; i++)
                send_pixel(8'($urandom_range(255)), i == n - 1);
        end
    endtask

    // Pixels that rarely repeat assign a new code for nearly every pixel.
    task automatic test_distinct_pixels();
        for (int i = 0; i < 30; i++)
            send_pixel(8'(i * 7 + (i >> 3)), i == 29);
    endtask

    task automatic test_receiver_stall();
        stall_cycles = 400;
        for (int i = 0; i < 40; i++) send_pixel(8'($urandom_range(3)), i == 39);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (byte_queue.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        errors        = 0;
        idle_enable   = 1'b1;
        stall_cycles  = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_pixel_index = '0;
        i_last_pixel  = 1'b0;
        i_ready       = 1'b0;
        pred_reset();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_single_pixels();
        test_extremes();
        test_runs();
        idle_enable = 1'b0;
        test_random_images();
        idle_enable = 1'b1;
        test_random_images();
        test_distinct_pixels();
        test_receiver_stall();
        drain();
        if (errors == 0 && byte_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/gle_pkg.sv
rtl/core/gle_front.sv
rtl/core/gle_engine.sv
rtl/core/gle_packer.sv
rtl/core/gif_lzw_encoder_unit.sv
tb/gif_lzw_encoder_unit_tb.sv
